// ===== design/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and constants for the JSON string unescaper with UTF-8
// checking: item formats, queue sizing and the result kinds.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Width of the decoded length counter and of the capacity register.
  localparam int unsigned LEN_W = 16;
  // Code point width (up to U+10FFFF).
  localparam int unsigned CP_W = 21;

  // Depth of the queue between the parser and the emitter.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY       = 1'b0;
  localparam logic CFG_OUTPUT_PRESENT = 1'b1;
  localparam logic [LEN_W-1:0] CAPACITY_RESET = '1;

  // Kind of result; the codes equal the status field of the output item.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } res_kind_e;

  // Input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Output item.
  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       status;
    logic [LEN_W-1:0] out_length;
    logic             run_end;
  } out_t;

  // All results caused by one input item, as handed from parser to emitter.
  typedef struct packed {
    res_kind_e        kind;
    logic [3:0][7:0]  enc;       // encoded UTF-8 bytes, first byte in slot 0
    logic [1:0]       last_idx;  // number of data bytes minus one
    logic [LEN_W-1:0] base_len;  // decoded length before these results
  } bundle_t;

endpackage

// ===== design/jsu_front.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape parser
// Accepts one byte per cycle while the queue has room, tracks the string,
// escape and UTF-8 state and hands bundles of results to the emitter.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [jsu_pkg::LEN_W-1:0] cap_i,
  input  logic                    opres_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  jsu_pkg::in_t            in_data_i,
  input  logic                    full_i,
  output logic                    push_o,
  output jsu_pkg::bundle_t        bundle_o
);

  // Parser modes, one-hot.
  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_BODY    = 8'b0000_0010,
    MODE_UTF8    = 8'b0000_0100,
    MODE_ESC     = 8'b0000_1000,
    MODE_HEX1    = 8'b0001_0000,
    MODE_PAIR_BS = 8'b0010_0000,
    MODE_PAIR_U  = 8'b0100_0000,
    MODE_HEX2    = 8'b1000_0000
  } mode_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  // Hex digit decode: valid flag over the four-bit value.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  mode_e                       mode_q, mode_n, mode_d;
  logic [jsu_pkg::LEN_W-1:0]   len_q, len_d;
  logic [jsu_pkg::CP_W-1:0]    acc_q, acc_n;
  logic [2:0]                  left_q, left_n;
  logic [2:0]                  seq_q, seq_n;
  logic [9:0]                  hh_q, hh_n;

  logic                        accept;
  logic [7:0]                  b;
  logic [4:0]                  hx;
  logic [15:0]                 acc16;
  logic [jsu_pkg::CP_W-1:0]    cont_acc;
  logic [jsu_pkg::CP_W-1:0]    min_cp;
  logic [2:0]                  left_dec;
  logic                        err1, done1, ap_req, esc_chk;
  logic [jsu_pkg::CP_W-1:0]    ap_cp;
  logic [2:0]                  n_bytes;
  logic [3:0][7:0]             enc;
  logic [jsu_pkg::LEN_W:0]     sum;
  logic                        cap_err, ap_ok;
  logic [jsu_pkg::LEN_W-1:0]   len_after;
  logic                        push;
  jsu_pkg::bundle_t            bundle;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !full_i;
  assign b          = in_data_i.in_byte;

  // Byte classification and next parser state.
  always_comb begin
    mode_n   = mode_q;
    acc_n    = acc_q;
    left_n   = left_q;
    seq_n    = seq_q;
    hh_n     = hh_q;
    err1     = 1'b0;
    done1    = 1'b0;
    ap_req   = 1'b0;
    esc_chk  = 1'b0;
    ap_cp    = '0;
    hx       = hex_val(b);
    acc16    = {acc_q[11:0], hx[3:0]};
    left_dec = left_q - 3'd1;
    cont_acc = {acc_q[14:0], b[5:0]};
    min_cp   = (seq_q == 3'd2) ? 21'h80 : ((seq_q == 3'd3) ? 21'h800 : 21'h10000);
    unique case (mode_q)
      MODE_IDLE: begin
        if (b == CH_QUOTE) begin
          mode_n = MODE_BODY;
        end else begin
          err1 = 1'b1;
        end
      end
      MODE_BODY: begin
        if (b == CH_QUOTE) begin
          if (opres_i && len_q >= cap_i) begin
            err1 = 1'b1;
          end else begin
            done1  = 1'b1;
            mode_n = MODE_IDLE;
          end
        end else if (b < 8'h20) begin
          err1 = 1'b1;
        end else if (b == CH_BSL) begin
          mode_n = MODE_ESC;
        end else if (b < 8'h80) begin
          ap_req = 1'b1;
          ap_cp  = 21'(b);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          acc_n  = 21'(b[4:0]);
          seq_n  = 3'd2;
          left_n = 3'd1;
          mode_n = MODE_UTF8;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          acc_n  = 21'(b[3:0]);
          seq_n  = 3'd3;
          left_n = 3'd2;
          mode_n = MODE_UTF8;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          acc_n  = 21'(b[2:0]);
          seq_n  = 3'd4;
          left_n = 3'd3;
          mode_n = MODE_UTF8;
        end else begin
          err1 = 1'b1;
        end
      end
      MODE_UTF8: begin
        if (b[7:6] != 2'b10) begin
          err1 = 1'b1;
        end else begin
          acc_n  = cont_acc;
          left_n = left_dec;
          if (left_dec == 3'd0) begin
            mode_n = MODE_BODY;
            // Overlong forms, values above U+10FFFF and surrogates are refused.
            if (cont_acc < min_cp || cont_acc > 21'h10FFFF ||
                (cont_acc >= 21'hD800 && cont_acc <= 21'hDFFF)) begin
              err1 = 1'b1;
            end else begin
              ap_req = 1'b1;
              ap_cp  = cont_acc;
            end
          end
        end
      end
      MODE_ESC: begin
        mode_n  = MODE_BODY;
        ap_req  = 1'b1;
        esc_chk = 1'b1;
        unique case (b)
          8'h22:   ap_cp = 21'h22;
          8'h5C:   ap_cp = 21'h5C;
          8'h2F:   ap_cp = 21'h2F;
          8'h62:   ap_cp = 21'h08;
          8'h66:   ap_cp = 21'h0C;
          8'h6E:   ap_cp = 21'h0A;
          8'h72:   ap_cp = 21'h0D;
          8'h74:   ap_cp = 21'h09;
          8'h75: begin
            ap_req  = 1'b0;
            esc_chk = 1'b0;
            acc_n   = '0;
            left_n  = 3'd4;
            mode_n  = MODE_HEX1;
          end
          default: begin
            ap_req  = 1'b0;
            esc_chk = 1'b0;
            err1    = 1'b1;
          end
        endcase
      end
      MODE_HEX1: begin
        if (!hx[4]) begin
          err1 = 1'b1;
        end else begin
          acc_n  = 21'(acc16);
          left_n = left_dec;
          if (left_dec == 3'd0) begin
            if (acc16 >= 16'hD800 && acc16 <= 16'hDBFF) begin
              hh_n   = acc16[9:0];
              mode_n = MODE_PAIR_BS;
            end else if (acc16 >= 16'hDC00 && acc16 <= 16'hDFFF) begin
              // A lone low surrogate.
              err1 = 1'b1;
            end else begin
              mode_n  = MODE_BODY;
              ap_req  = 1'b1;
              esc_chk = 1'b1;
              ap_cp   = 21'(acc16);
            end
          end
        end
      end
      MODE_PAIR_BS: begin
        if (b == CH_BSL) begin
          mode_n = MODE_PAIR_U;
        end else begin
          err1 = 1'b1;
        end
      end
      MODE_PAIR_U: begin
        if (b == CH_U) begin
          acc_n  = '0;
          left_n = 3'd4;
          mode_n = MODE_HEX2;
        end else begin
          err1 = 1'b1;
        end
      end
      MODE_HEX2: begin
        if (!hx[4]) begin
          err1 = 1'b1;
        end else begin
          acc_n  = 21'(acc16);
          left_n = left_dec;
          if (left_dec == 3'd0) begin
            if (acc16 < 16'hDC00 || acc16 > 16'hDFFF) begin
              err1 = 1'b1;
            end else begin
              mode_n  = MODE_BODY;
              ap_req  = 1'b1;
              esc_chk = 1'b1;
              ap_cp   = 21'h10000 + {1'b0, hh_q, acc16[9:0]};
            end
          end
        end
      end
      default: begin
        err1 = 1'b1;
      end
    endcase
    // An escaped NUL is refused when an output buffer is present.
    if (esc_chk && opres_i && ap_cp == '0) begin
      err1 = 1'b1;
    end
  end

  // UTF-8 encoding of the code point to append.
  always_comb begin
    enc = '0;
    if (ap_cp <= 21'h7F) begin
      n_bytes = 3'd1;
      enc[0]  = ap_cp[7:0];
    end else if (ap_cp <= 21'h7FF) begin
      n_bytes = 3'd2;
      enc[0]  = {3'b110, ap_cp[10:6]};
      enc[1]  = {2'b10, ap_cp[5:0]};
    end else if (ap_cp <= 21'hFFFF) begin
      n_bytes = 3'd3;
      enc[0]  = {4'b1110, ap_cp[15:12]};
      enc[1]  = {2'b10, ap_cp[11:6]};
      enc[2]  = {2'b10, ap_cp[5:0]};
    end else begin
      n_bytes = 3'd4;
      enc[0]  = {5'b11110, ap_cp[20:18]};
      enc[1]  = {2'b10, ap_cp[17:12]};
      enc[2]  = {2'b10, ap_cp[11:6]};
      enc[3]  = {2'b10, ap_cp[5:0]};
    end
  end

  // Capacity check on the append.
  assign sum       = {1'b0, len_q} + (jsu_pkg::LEN_W + 1)'(n_bytes);
  assign cap_err   = sum > {1'b0, cap_i};
  assign ap_ok     = ap_req && !err1 && !cap_err;
  assign len_after = ap_ok ? sum[jsu_pkg::LEN_W-1:0] : len_q;

  // Result selection; an open string on the last byte turns into an error.
  always_comb begin
    bundle          = '0;
    bundle.kind     = jsu_pkg::KIND_DATA;
    bundle.enc      = enc;
    bundle.last_idx = 2'(n_bytes - 3'd1);
    bundle.base_len = len_q;
    push            = 1'b0;
    mode_d          = mode_n;
    len_d           = len_after;
    if (err1 || (ap_req && cap_err)) begin
      bundle.kind = jsu_pkg::KIND_ERROR;
      push        = 1'b1;
      mode_d      = MODE_IDLE;
      len_d       = '0;
    end else if (in_data_i.in_last && mode_n != MODE_IDLE) begin
      bundle.kind     = jsu_pkg::KIND_ERROR;
      bundle.base_len = len_after;
      push            = 1'b1;
      mode_d          = MODE_IDLE;
      len_d           = '0;
    end else if (done1) begin
      bundle.kind = jsu_pkg::KIND_DONE;
      push        = 1'b1;
      len_d       = '0;
    end else if (ap_ok) begin
      push = 1'b1;
    end
  end

  assign push_o   = accept && push;
  assign bundle_o = bundle;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      acc_q  <= '0;
      left_q <= '0;
      seq_q  <= '0;
      hh_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_n;
      left_q <= left_n;
      seq_q  <= seq_n;
      hh_q   <= hh_n;
    end
  end

endmodule

// ===== design/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape result queue
// A short first-in first-out queue of result bundles between the parser and
// the emitter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsu_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output jsu_pkg::bundle_t head_o
);

  jsu_pkg::bundle_t               mem_q [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [jsu_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = cnt_q == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/jsu_back.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape emitter
// Sends the queue head's results one per cycle while out_ready_i is high:
// the decoded bytes with running lengths, or a done or error item.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  jsu_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jsu_pkg::out_t    out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       is_last;
  logic       fire;

  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;
  assign is_last     = (head_i.kind != jsu_pkg::KIND_DATA) || (idx_q == head_i.last_idx);
  assign pop_o       = fire && is_last;

  // Output item built from the head bundle and the byte index.
  always_comb begin
    out_data_o         = '0;
    out_data_o.status  = head_i.kind;
    out_data_o.run_end = is_last;
    if (head_i.kind == jsu_pkg::KIND_DATA) begin
      out_data_o.out_byte   = head_i.enc[idx_q];
      out_data_o.out_length = head_i.base_len + jsu_pkg::LEN_W'(idx_q) + 1'b1;
    end else begin
      out_data_o.out_length = head_i.base_len;
    end
  end

  // Byte index within the current bundle.
  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== design/json_string_unescape_utf8_core.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape core
// Decodes a JSON string one raw byte at a time with strict UTF-8 checking.
// ----------------------------------------------------------------------------
// Usage: raw bytes arrive on the input channel (in_valid_i / in_ready_o), one
// item per byte, with in_last set on the final byte of the buffer. Results
// leave on the output channel (out_valid_o / out_ready_i): decoded bytes with
// their running length, then a done item with the final length, or a single
// error item. run_end marks the last result caused by an input byte.
// A byte is taken in every cycle while the four-entry result queue has room;
// its results wait in the queue behind those already there. The emitter sends
// one result per cycle while the receiver is ready, n for a code point of n
// UTF-8 bytes; bytes with no result (opening quote, escape, hex digits, lead
// bytes) cost the output nothing. When the receiver stalls, the queue fills
// and in_ready_o drops; nothing is lost. Reset empties the queue, puts the
// parser back to waiting for an opening quote and sets capacity to 65535 and
// output-present to zero. The configuration port writes a register in the
// cycle cfg_we_i is high; it is meant to be used only while the block is idle.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [jsu_pkg::LEN_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  jsu_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output jsu_pkg::out_t             out_data_o
);

  logic [jsu_pkg::LEN_W-1:0] cap_q;
  logic                      opres_q;
  logic                      full, empty, push, pop;
  jsu_pkg::bundle_t          bundle, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= jsu_pkg::CAPACITY_RESET;
      opres_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jsu_pkg::CFG_CAPACITY:       cap_q   <= cfg_wdata_i;
        jsu_pkg::CFG_OUTPUT_PRESENT: opres_q <= cfg_wdata_i[0];
        default:                     cap_q   <= cap_q;
      endcase
    end
  end

  // Parser front.
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_q),
    .opres_i    (opres_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  // Result queue.
  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Result emitter.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
